@@ hw/rtl/ccol_pkg.sv @@
`timescale 1ns / 1ps

package ccol_pkg;

	// default coordinate width (signed fixed point)
	localparam int COORD_BITS_DEF = 16;

	// fraction bits of the projection parameter t
	localparam int T_BITS = 16;

	// shape kind codes
	localparam logic [1:0] OP_NONE     = 2'd0;
	localparam logic [1:0] OP_CIRCLE   = 2'd1;
	localparam logic [1:0] OP_SEGMENT  = 2'd2;
	localparam logic [1:0] OP_RESERVED = 2'd3;

	// accept-to-result latency in cycles
	localparam int LATENCY = 25;

endpackage

@@ hw/rtl/ccol_div_stage.sv @@
`timescale 1ns / 1ps

module ccol_div_stage #(
	parameter int RW = 36,
	parameter int QW = 16,
	parameter int SW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          vld_in,
	input  logic [RW-1:0] rem_in,
	input  logic [RW-2:0] den_in,
	input  logic [QW-1:0] q_in,
	input  logic [SW-1:0] sb_in,
	output logic          vld_out,
	output logic [RW-1:0] rem_out,
	output logic [RW-2:0] den_out,
	output logic [QW-1:0] q_out,
	output logic [SW-1:0] sb_out
);

	logic [RW-1:0] sh;
	logic [RW-1:0] dif;
	logic          ge;

	// one restoring step: shift, trial subtract, keep on success
	assign sh  = {rem_in[RW-2:0], 1'b0};
	assign ge  = sh >= {1'b0, den_in};
	assign dif = sh - {1'b0, den_in};

	// advance valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else begin
			vld_out <= vld_in;
		end
	end

	// advance payload
	always_ff @(posedge clk) begin
		rem_out <= ge ? dif : sh;
		q_out   <= {q_in[QW-2:0], ge};
		den_out <= den_in;
		sb_out  <= sb_in;
	end

endmodule

@@ hw/rtl/circle_collision_test.sv @@
`timescale 1ns / 1ps

// Circle against circle or line segment overlap test, fully pipelined.
// Pipeline: an accepted item passes 4 front stages, 16 divider steps and 5 back stages.
// Throughput: one item per cycle; busy stays low, the receiver cannot stall.
// Reset: arst_n clears all valid bits at once; items in flight are dropped.
module circle_collision_test #(
	parameter int COORD_BITS = ccol_pkg::COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [1:0]                   op,
	input  logic signed [COORD_BITS-1:0] center_x,
	input  logic signed [COORD_BITS-1:0] center_y,
	input  logic [COORD_BITS-2:0]        radius,
	input  logic signed [COORD_BITS-1:0] first_x,
	input  logic signed [COORD_BITS-1:0] first_y,
	input  logic signed [COORD_BITS-1:0] second_x,
	input  logic signed [COORD_BITS-1:0] second_y,
	input  logic [COORD_BITS-2:0]        other_radius,
	output logic                         done,
	output logic                         hit
);

	localparam int TB   = ccol_pkg::T_BITS;
	localparam int DW   = COORD_BITS + 1;
	localparam int SQW  = 2 * DW;
	localparam int D2W  = 2 * DW + 1;
	localparam int NW   = 2 * DW + 1;
	localparam int RW   = D2W + 1;
	localparam int R2W  = 2 * (COORD_BITS - 1);
	localparam int S2W  = 2 * COORD_BITS;
	localparam int SBW  = 3 + 4 * DW + R2W;
	localparam int PW   = DW + TB + 2;
	localparam int OW   = DW + 2;
	localparam int EW   = DW + 3;
	localparam int ESW  = 2 * EW;

	assign busy = 1'b0;

	// stage 1: differences
	logic                   vld_s1;
	logic [1:0]             op_s1;
	logic signed [DW-1:0]   dax_s1, day_s1, dbx_s1, dby_s1;
	logic signed [DW-1:0]   abx_s1, aby_s1, acx_s1, acy_s1;
	logic [COORD_BITS-2:0]  r_s1;
	logic [COORD_BITS-1:0]  s_s1;

	// stage 2: products
	logic                   vld_s2;
	logic [1:0]             op_s2;
	logic signed [SQW-1:0]  sqax_s2, sqay_s2, sqbx_s2, sqby_s2, sqabx_s2, sqaby_s2;
	logic signed [SQW-1:0]  pnx_s2, pny_s2;
	logic [R2W-1:0]         r2_s2;
	logic [S2W-1:0]         s2_s2;
	logic signed [DW-1:0]   dax_s2, day_s2, abx_s2, aby_s2;

	// stage 3: sums
	logic                   vld_s3;
	logic [1:0]             op_s3;
	logic [D2W-1:0]         dista_s3, distb_s3, den_s3;
	logic signed [NW-1:0]   num_s3;
	logic [R2W-1:0]         r2_s3;
	logic [S2W-1:0]         s2_s3;
	logic signed [DW-1:0]   dax_s3, day_s3, abx_s3, aby_s3;

	// stage 4: decisions and divider setup
	logic                   vld_s4;
	logic [RW-1:0]          rem_s4;
	logic [D2W-1:0]         den_s4;
	logic [SBW-1:0]         sb_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	logic end_hit, need_proj, pre_hit, num_ok;
	logic [D2W-1:0] num_mag;

	// classify the item from the sums
	always_comb begin
		num_mag   = {1'b0, num_s3[NW-2:0]};
		end_hit   = (dista_s3 <= D2W'(r2_s3)) || (distb_s3 <= D2W'(r2_s3));
		num_ok    = !num_s3[NW-1] && (num_mag <= den_s3);
		need_proj = (op_s3 == ccol_pkg::OP_SEGMENT) && !end_hit
			&& (den_s3 != '0) && num_ok;
		pre_hit   = ((op_s3 == ccol_pkg::OP_CIRCLE) && (dista_s3 <= D2W'(s2_s3)))
			|| ((op_s3 == ccol_pkg::OP_SEGMENT) && end_hit);
	end

	always_ff @(posedge clk) begin
		// stage 1
		op_s1  <= op;
		dax_s1 <= DW'(first_x) - DW'(center_x);
		day_s1 <= DW'(first_y) - DW'(center_y);
		dbx_s1 <= DW'(second_x) - DW'(center_x);
		dby_s1 <= DW'(second_y) - DW'(center_y);
		abx_s1 <= DW'(second_x) - DW'(first_x);
		aby_s1 <= DW'(second_y) - DW'(first_y);
		acx_s1 <= DW'(center_x) - DW'(first_x);
		acy_s1 <= DW'(center_y) - DW'(first_y);
		r_s1   <= radius;
		s_s1   <= COORD_BITS'(radius) + COORD_BITS'(other_radius);
		// stage 2
		op_s2    <= op_s1;
		sqax_s2  <= dax_s1 * dax_s1;
		sqay_s2  <= day_s1 * day_s1;
		sqbx_s2  <= dbx_s1 * dbx_s1;
		sqby_s2  <= dby_s1 * dby_s1;
		sqabx_s2 <= abx_s1 * abx_s1;
		sqaby_s2 <= aby_s1 * aby_s1;
		pnx_s2   <= abx_s1 * acx_s1;
		pny_s2   <= aby_s1 * acy_s1;
		r2_s2    <= R2W'(r_s1) * R2W'(r_s1);
		s2_s2    <= S2W'(s_s1) * S2W'(s_s1);
		dax_s2   <= dax_s1;
		day_s2   <= day_s1;
		abx_s2   <= abx_s1;
		aby_s2   <= aby_s1;
		// stage 3
		op_s3    <= op_s2;
		dista_s3 <= {1'b0, sqax_s2} + {1'b0, sqay_s2};
		distb_s3 <= {1'b0, sqbx_s2} + {1'b0, sqby_s2};
		den_s3   <= {1'b0, sqabx_s2} + {1'b0, sqaby_s2};
		num_s3   <= {pnx_s2[SQW-1], pnx_s2} + {pny_s2[SQW-1], pny_s2};
		r2_s3    <= r2_s2;
		s2_s3    <= s2_s2;
		dax_s3   <= dax_s2;
		day_s3   <= day_s2;
		abx_s3   <= abx_s2;
		aby_s3   <= aby_s2;
		// stage 4
		rem_s4 <= need_proj ? {1'b0, num_mag} : '0;
		den_s4 <= need_proj ? den_s3 : {{(D2W-1){1'b0}}, 1'b1};
		sb_s4  <= {pre_hit, need_proj, (num_mag == den_s3),
			dax_s3, day_s3, abx_s3, aby_s3, r2_s3};
	end

	// divider chain: one quotient bit per stage
	logic            dv_vld [0:TB];
	logic [RW-1:0]   dv_rem [0:TB];
	logic [D2W-1:0]  dv_den [0:TB];
	logic [TB-1:0]   dv_q   [0:TB];
	logic [SBW-1:0]  dv_sb  [0:TB];

	assign dv_vld[0] = vld_s4;
	assign dv_rem[0] = rem_s4;
	assign dv_den[0] = den_s4;
	assign dv_q[0]   = '0;
	assign dv_sb[0]  = sb_s4;

	for (genvar k = 0; k < TB; k++) begin : g_div
		ccol_div_stage #(
			.RW(RW),
			.QW(TB),
			.SW(SBW)
		) u_stage (
			.clk    (clk),
			.arst_n (arst_n),
			.vld_in (dv_vld[k]),
			.rem_in (dv_rem[k]),
			.den_in (dv_den[k]),
			.q_in   (dv_q[k]),
			.sb_in  (dv_sb[k]),
			.vld_out(dv_vld[k+1]),
			.rem_out(dv_rem[k+1]),
			.den_out(dv_den[k+1]),
			.q_out  (dv_q[k+1]),
			.sb_out (dv_sb[k+1])
		);
	end

	// unpack sideband after the divider
	logic                 d_pre, d_need, d_eq;
	logic signed [DW-1:0] d_dax, d_day, d_abx, d_aby;
	logic [R2W-1:0]       d_r2;
	logic [TB:0]          d_t;

	assign {d_pre, d_need, d_eq, d_dax, d_day, d_abx, d_aby, d_r2} = dv_sb[TB];
	assign d_t = d_eq ? {1'b1, {TB{1'b0}}} : {1'b0, dv_q[TB]};

	// back stages
	logic                 vld_s5, vld_s6, vld_s7, vld_s8;
	logic                 pre_s5, pre_s6, pre_s7, pre_s8;
	logic                 need_s5, need_s6, need_s7, need_s8;
	logic [R2W-1:0]       r2_s5, r2_s6, r2_s7, r2_s8;
	logic signed [DW-1:0] dax_s5, day_s5, dax_s6, day_s6;
	logic signed [PW-1:0] px_s5, py_s5;
	logic signed [OW-1:0] offx_s6, offy_s6;
	logic signed [EW-1:0] ex_s7, ey_s7;
	logic [ESW-1:0]       sqx_s8, sqy_s8;

	logic [PW-1:0]        magx, magy;
	logic [PW-1:0]        rndx, rndy;
	logic [OW-1:0]        rx, ry;

	// round offsets half away from zero
	always_comb begin
		magx = px_s5[PW-1] ? PW'(-px_s5) : PW'(px_s5);
		magy = py_s5[PW-1] ? PW'(-py_s5) : PW'(py_s5);
		rndx = (magx + (PW'(1) << (TB - 1))) >> TB;
		rndy = (magy + (PW'(1) << (TB - 1))) >> TB;
		rx   = rndx[OW-1:0];
		ry   = rndy[OW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			done   <= 1'b0;
		end else begin
			vld_s5 <= dv_vld[TB];
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
			done   <= vld_s8;
		end
	end

	always_ff @(posedge clk) begin
		// stage 5: scale segment by t
		px_s5   <= d_abx * $signed({1'b0, d_t});
		py_s5   <= d_aby * $signed({1'b0, d_t});
		dax_s5  <= d_dax;
		day_s5  <= d_day;
		pre_s5  <= d_pre;
		need_s5 <= d_need;
		r2_s5   <= d_r2;
		// stage 6: rounded offsets
		offx_s6 <= px_s5[PW-1] ? -$signed(rx) : $signed(rx);
		offy_s6 <= py_s5[PW-1] ? -$signed(ry) : $signed(ry);
		dax_s6  <= dax_s5;
		day_s6  <= day_s5;
		pre_s6  <= pre_s5;
		need_s6 <= need_s5;
		r2_s6   <= r2_s5;
		// stage 7: closest point relative to center
		ex_s7   <= EW'(dax_s6) + EW'(offx_s6);
		ey_s7   <= EW'(day_s6) + EW'(offy_s6);
		pre_s7  <= pre_s6;
		need_s7 <= need_s6;
		r2_s7   <= r2_s6;
		// stage 8: squares
		sqx_s8  <= ESW'(ex_s7) * ESW'(ex_s7);
		sqy_s8  <= ESW'(ey_s7) * ESW'(ey_s7);
		pre_s8  <= pre_s7;
		need_s8 <= need_s7;
		r2_s8   <= r2_s7;
		// result, held low while no item leaves
		hit <= vld_s8 && (pre_s8 || (need_s8
			&& (({1'b0, sqx_s8} + {1'b0, sqy_s8}) <= (ESW + 1)'(r2_s8))));
	end

endmodule

@@ hw/rtl/ccol_checker.sv @@
`timescale 1ns / 1ps

module ccol_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic [1:0] op,
	input logic       done,
	input logic       hit
);

	localparam int LAT = ccol_pkg::LATENCY;

	logic [5:0] warm_q;

	// count cycles since reset release, saturate at the latency
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			warm_q <= '0;
		end else if (warm_q != 6'(LAT)) begin
			warm_q <= warm_q + 6'd1;
		end
	end

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(warm_q == 6'(LAT)) |-> (done == $past(start && !busy, LAT)))
		else $error("done does not match accepted item");

	a_none_miss: assert property (@(posedge clk) disable iff (!arst_n)
		((warm_q == 6'(LAT)) && $past(start && !busy
			&& (op == ccol_pkg::OP_NONE || op == ccol_pkg::OP_RESERVED), LAT)) |-> !hit)
		else $error("hit for op without shape");

	a_hit_done: assert property (@(posedge clk) disable iff (!arst_n)
		hit |-> done)
		else $error("hit without done");

	a_no_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("busy raised");

endmodule

bind circle_collision_test ccol_checker u_ccol_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.op    (op),
	.done  (done),
	.hit   (hit)
);

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

	localparam int CW = ccol_pkg::COORD_BITS_DEF;
	localparam int WATCHDOG_LIMIT = 2000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [1:0] op = ccol_pkg::OP_NONE;
	logic signed [CW-1:0] center_x = '0, center_y = '0, first_x = '0, first_y = '0;
	logic signed [CW-1:0] second_x = '0, second_y = '0;
	logic [CW-2:0] radius = '0, other_radius = '0;
	logic done, hit;

	bit hit_queue[$];
	int mismatches = 0;
	int results_seen = 0;
	int items_sent = 0;
	int hits_seen = 0;
	int idle_cycles = 0;
	bit allow_gaps = 1'b1;
	bit timed_out = 1'b0;

	circle_collision_test #(.COORD_BITS(CW)) i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .op(op),
		.center_x(center_x), .center_y(center_y), .radius(radius),
		.first_x(first_x), .first_y(first_y), .second_x(second_x),
		.second_y(second_y), .other_radius(other_radius), .done(done), .hit(hit)
	);

	always #5 clk = ~clk;

	// square of a coordinate difference, exact in 64 bits
	function automatic longint sq64(longint v);
		return v * v;
	endfunction

	// scale an offset by Q1.16 t, round half away from zero
	function automatic longint scale_by_t(longint v, longint t);
		longint p, r;
		p = v * t;
		r = ((p < 0 ? -p : p) + (longint'(1) << (ccol_pkg::T_BITS - 1)))
			>>> ccol_pkg::T_BITS;
		return p < 0 ? -r : r;
	endfunction

	// predict the overlap result for one item
	function automatic bit predict_hit(logic [1:0] k, longint cx, longint cy, longint r,
			longint ax, longint ay, longint bx, longint by, longint orad);
		longint r2, abx, aby, acx, acy, num, den, t, px, py;
		if (k == ccol_pkg::OP_CIRCLE)
			return sq64(cx - ax) + sq64(cy - ay) <= sq64(r + orad);
		if (k != ccol_pkg::OP_SEGMENT)
			return 1'b0;
		r2 = r * r;
		if (sq64(ax - cx) + sq64(ay - cy) <= r2 || sq64(bx - cx) + sq64(by - cy) <= r2)
			return 1'b1;
		abx = bx - ax; aby = by - ay; acx = cx - ax; acy = cy - ay;
		den = sq64(abx) + sq64(aby);
		num = abx * acx + aby * acy;
		if (den == 0 || num < 0 || num > den)
			return 1'b0;
		t = (num << ccol_pkg::T_BITS) / den;
		px = ax + scale_by_t(abx, t);
		py = ay + scale_by_t(aby, t);
		return sq64(px - cx) + sq64(py - cy) <= r2;
	endfunction

	// drive one item and wait for its acceptance
	task automatic send_item(logic [1:0] k, logic [CW-1:0] cx, logic [CW-1:0] cy,
			logic [CW-2:0] r, logic [CW-1:0] ax, logic [CW-1:0] ay, logic [CW-1:0] bx,
			logic [CW-1:0] by, logic [CW-2:0] orad);
		int gap;
		if (allow_gaps && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 14);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		op <= k; center_x <= cx; center_y <= cy; radius <= r; first_x <= ax;
		first_y <= ay; second_x <= bx; second_y <= by; other_radius <= orad;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		hit_queue.push_back(predict_hit(k, $signed(cx), $signed(cy), r, $signed(ax),
			$signed(ay), $signed(bx), $signed(by), orad));
		items_sent++;
	endtask

	// check each result against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && done) begin
			results_seen++;
			if (hit_queue.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: unexpected result hit=%0b", hit);
			end else begin
				if (hit !== hit_queue[0]) begin
					mismatches++;
					if (mismatches <= 10)
						$display("ERROR: item %0d hit expected %0b got %0b",
							results_seen - 1, hit_queue[0], hit);
				end
				void'(hit_queue.pop_front());
			end
			hits_seen += hit;
		end
	end

	// end the run when nothing is accepted or finished for too long
	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else if (arst_n)
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic test_extremes();
		send_item(ccol_pkg::OP_NONE, 0, 0, 0, 0, 0, 0, 0, 0);
		send_item(ccol_pkg::OP_RESERVED, 0, 0, 15'h7fff, 0, 0, 0, 0, 15'h7fff);
		send_item(ccol_pkg::OP_CIRCLE, 16'h8000, 16'h8000, 15'h7fff, 16'h7fff, 16'h7fff,
			0, 0, 15'h7fff);
		send_item(ccol_pkg::OP_CIRCLE, 16'h8000, 16'h8000, 0, 16'h7fff, 16'h7fff,
			16'hffff, 16'hffff, 0);
		send_item(ccol_pkg::OP_CIRCLE, 0, 0, 0, 0, 0, 0, 0, 0);
		send_item(ccol_pkg::OP_CIRCLE, 0, 0, 3, 5, 0, 0, 0, 2);
		send_item(ccol_pkg::OP_CIRCLE, 0, 0, 3, 6, 0, 0, 0, 2);
		send_item(ccol_pkg::OP_SEGMENT, 16'h7fff, 16'h7fff, 15'h7fff, 16'h8000, 16'h8000,
			16'h8000, 16'h7fff, 0);
	endtask

	task automatic test_segment_cases();
		send_item(ccol_pkg::OP_SEGMENT, 0, 0, 10, 5, 5, 100, 100, 0);
		send_item(ccol_pkg::OP_SEGMENT, 0, 0, 10, 100, 100, 5, 5, 0);
		send_item(ccol_pkg::OP_SEGMENT, 0, 0, 10, 50, 50, 50, 50, 0);
		send_item(ccol_pkg::OP_SEGMENT, 0, 0, 10, -100, 5, 100, 5, 0);
		send_item(ccol_pkg::OP_SEGMENT, 0, 0, 10, -100, 10, 100, 10, 0);
		send_item(ccol_pkg::OP_SEGMENT, 0, 0, 10, -100, 11, 100, 11, 0);
		send_item(ccol_pkg::OP_SEGMENT, 0, 0, 10, 20, 0, 100, 0, 0);
		send_item(ccol_pkg::OP_SEGMENT, 0, 0, 10, -100, 0, -20, 0, 0);
		send_item(ccol_pkg::OP_SEGMENT, 16'h8000, 0, 15'h7fff, 16'h8000, 16'h8000,
			16'h7fff, 16'h7fff, 0);
		send_item(ccol_pkg::OP_SEGMENT, 3, 7, 4, -300, 11, 301, 12, 0);
	endtask

	task automatic test_random(int count);
		logic [CW-1:0] cx, cy, ax, ay, bx, by, span;
		logic [CW-2:0] r, orad;
		int mode;
		for (int i = 0; i < count; i++) begin
			if (i > count * 4 / 5)
				allow_gaps = 1'b0;
			mode = $urandom_range(0, 9);
			// most items sit in a local window so hits and misses both occur
			span = (mode < 7) ? CW'($urandom_range(16, 4000)) : 16'h7fff;
			cx = CW'($urandom); cy = CW'($urandom);
			if (mode < 7) begin
				ax = cx + $signed(CW'($urandom_range(0, 2 * span))) - $signed(span);
				ay = cy + $signed(CW'($urandom_range(0, 2 * span))) - $signed(span);
				bx = cx + $signed(CW'($urandom_range(0, 2 * span))) - $signed(span);
				by = cy + $signed(CW'($urandom_range(0, 2 * span))) - $signed(span);
				r = (CW-1)'($urandom_range(0, span));
				orad = (CW-1)'($urandom_range(0, span));
			end else begin
				ax = CW'($urandom); ay = CW'($urandom);
				bx = CW'($urandom); by = CW'($urandom);
				r = (CW-1)'($urandom); orad = (CW-1)'($urandom);
			end
			if (mode == 6) begin
				bx = ax; by = ay;
			end
			send_item(mode == 9 ? 2'($urandom_range(0, 3)) :
				($urandom_range(0, 2) == 0 ? ccol_pkg::OP_CIRCLE : ccol_pkg::OP_SEGMENT),
				cx, cy, r, ax, ay, bx, by, orad);
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_segment_cases();
		test_random(930);
		start <= 1'b0;
		while (hit_queue.size() != 0 && !timed_out) begin
			@(posedge clk);
			if (idle_cycles > ccol_pkg::LATENCY * 4)
				timed_out = 1'b1;
		end
		repeat (ccol_pkg::LATENCY + 5) @(posedge clk);
		$display("Sent %0d items (circle, segment, none and unused op),",
			items_sent);
		$display("  %0d hits of %0d results", hits_seen, results_seen);
		if (mismatches == 0 && !timed_out && hit_queue.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
